// ===== rtl/osa_pkg.sv =====
// Shared types, command codes and the saturating adder for the weighted
// optimal-string-alignment distance block. No dependencies.
`default_nettype none

package osa_pkg;

  // Command carried with every input beat.
  typedef enum logic [1:0] {
    CMD_CLEAR      = 2'd0,
    CMD_PUSH_RIGHT = 2'd1,
    CMD_PUSH_LEFT  = 2'd2,
    CMD_REPORT     = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_INSERT  = 2'd0;
  localparam logic [1:0] REG_REMOVE  = 2'd1;
  localparam logic [1:0] REG_REPLACE = 2'd2;
  localparam logic [1:0] REG_SWAP    = 2'd3;

  localparam logic [7:0] COST_RESET = 8'd1;

  typedef struct packed {
    logic [7:0] insert;
    logic [7:0] remove;
    logic [7:0] replace;
    logic [7:0] swap;
  } cost_t;

  // Adds an 8-bit cost to a row value and clamps the sum at lim.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [7:0] b,
                                          input logic [31:0] lim);
    logic [32:0] s;
    logic [31:0] r;
    s = {1'b0, a} + {25'b0, b};
    if (s > {1'b0, lim}) begin
      r = lim;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/osa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the right-string store and the three row banks. No dependencies.
`default_nettype none

module osa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/osa_cell.sv =====
// Shared cell unit: computes one new row entry from its neighbors, the
// stored characters and the costs. Depends on osa_pkg.
`default_nettype none

module osa_cell import osa_pkg::*; #(
  parameter int DW = 16
) (
  input  wire cost_t         cost_i,
  input  wire logic [DW-1:0] cur_diag_i,
  input  wire logic [DW-1:0] cur_up_i,
  input  wire logic [DW-1:0] old_diag_i,
  input  wire logic [DW-1:0] left_i,
  input  wire logic [7:0]    right_char_i,
  input  wire logic [7:0]    right_prev_i,
  input  wire logic [7:0]    left_char_i,
  input  wire logic [7:0]    prev_left_i,
  input  wire logic          swap_en_i,
  output logic      [DW-1:0] cell_o
);

  localparam logic [31:0] DistMax = 32'((64'd1 << DW) - 64'd1);

  logic [DW-1:0] t_diag, t_swap, t_rem, t_ins, v1, v2;
  logic          swap_hit;

  always_comb begin
    t_diag = DW'(sat_add(32'(cur_diag_i),
                         (right_char_i != left_char_i) ? cost_i.replace : 8'd0, DistMax));
    t_swap = DW'(sat_add(32'(old_diag_i), cost_i.swap, DistMax));
    t_rem  = DW'(sat_add(32'(cur_up_i), cost_i.remove, DistMax));
    t_ins  = DW'(sat_add(32'(left_i), cost_i.insert, DistMax));
    swap_hit = swap_en_i && (prev_left_i == right_char_i) && (left_char_i == right_prev_i);
    v1 = (swap_hit && (t_swap < t_diag)) ? t_swap : t_diag;
    v2 = (t_rem < v1) ? t_rem : v1;
    cell_o = (t_ins < v2) ? t_ins : v2;
  end

endmodule

`default_nettype wire

// ===== rtl/weighted_osa_edit_distance.sv =====
// Weighted optimal-string-alignment edit distance, top level.
// Clear, right push and report need no sweep; a left push onto a non-empty right
// string sweeps the row, with one shared cell unit stepping one column per cycle.
// A report's result appears the cycle after its beat is accepted.
// Asynchronous active-low reset returns all costs to 1 and empties the pair.
`default_nettype none

module weighted_osa_edit_distance import osa_pkg::*; #(
  parameter int MAX_LEN   = 64,
  parameter int DIST_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [15:0] edit_distance
  output logic      [0:0]  m_axis_tuser,   // [0] overflow
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int DW = DIST_BITS;
  localparam logic [31:0] DistMax = 32'((64'd1 << DIST_BITS) - 64'd1);
  localparam logic [LW-1:0] LenMax = LW'(MAX_LEN);

  typedef enum logic {ST_IDLE, ST_SWEEP} state_e;

  // Cost registers.
  cost_t cost_q;

  // Pair state. Column zero of each row lives in flip-flops; entries 1..MAX_LEN
  // live in three rotating row banks, entry e at address e-1.
  state_e        state_q;
  logic [LW-1:0] len_q;
  logic          left_seen_q;
  logic [7:0]    prev_left_q;
  logic          overflow_q;
  logic [DW-1:0] cur0_q, old0_q, next0_q;
  logic [DW-1:0] last_q;          // always equals current_row[right_length]
  logic [1:0]    cur_sel_q, old_sel_q, nxt_sel_q;

  // Sweep sequencer: issue stage (RAM reads) and compute stage.
  logic          issue_q;
  logic [AW-1:0] k_q;
  logic          cmp_valid_q, cmp_first_q, cmp_last_q;
  logic [AW-1:0] cmp_addr_q;
  logic [7:0]    left_char_q;
  logic [DW-1:0] cur_hold_q, old_hold_q, nxt_prev_q;
  logic [7:0]    rs_prev_q;

  // Output register.
  logic          m_valid_q;
  logic [15:0]   dist_q;
  logic          ovf_q;

  cmd_e          cmd;
  logic          s_fire;
  logic          right_wr;
  logic [DW-1:0] right_val;
  logic [DW-1:0] col0_next;
  logic [DW-1:0] cell_v;
  logic [7:0]    rs_rd;
  logic [DW-1:0] bank_rd [3];
  logic [DW-1:0] cur_rd, old_rd;
  logic [DW+15:0] last_ext;

  assign cmd    = cmd_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // A right push is stored only before any left push and while there is room.
  assign right_wr  = s_fire && (cmd == CMD_PUSH_RIGHT) && !left_seen_q && (len_q != LenMax);
  assign right_val = DW'(sat_add(32'(last_q), cost_q.insert, DistMax));
  assign col0_next = DW'(sat_add(32'(cur0_q), cost_q.remove, DistMax));

  assign cur_rd = bank_rd[cur_sel_q];
  assign old_rd = bank_rd[old_sel_q];

  osa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_right_store (
    .clk_i   (clk_i),
    .we_i    (right_wr),
    .waddr_i (AW'(len_q)),
    .wdata_i (s_axis_tdata),
    .raddr_i (k_q),
    .rdata_o (rs_rd)
  );

  // Three row banks rotate roles: current, older and the row being built.
  for (genvar b = 0; b < 3; b++) begin : g_bank
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata;

    always_comb begin
      we    = 1'b0;
      waddr = cmp_addr_q;
      wdata = cell_v;
      if (right_wr && (cur_sel_q == 2'(b))) begin
        we    = 1'b1;
        waddr = AW'(len_q);
        wdata = right_val;
      end else if (cmp_valid_q && (nxt_sel_q == 2'(b))) begin
        we = 1'b1;
      end
      // The older row is read one entry behind the current row.
      raddr = (old_sel_q == 2'(b)) ? (k_q - AW'(1)) : k_q;
    end

    osa_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_row (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .raddr_i (raddr),
      .rdata_o (bank_rd[b])
    );
  end

  // The cell at column j sees current_row[j-1] and current_row[j], older_row[j-2],
  // the freshly built next_row[j-1] and the right characters at j and j-1.
  osa_cell #(.DW(DW)) u_cell (
    .cost_i       (cost_q),
    .cur_diag_i   (cur_hold_q),
    .cur_up_i     (cur_rd),
    .old_diag_i   (old_hold_q),
    .left_i       (nxt_prev_q),
    .right_char_i (rs_rd),
    .right_prev_i (rs_prev_q),
    .left_char_i  (left_char_q),
    .prev_left_i  (prev_left_q),
    .swap_en_i    (left_seen_q && !cmp_first_q),
    .cell_o       (cell_v)
  );

  // The user must write configuration only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= '{insert: COST_RESET, remove: COST_RESET,
                  replace: COST_RESET, swap: COST_RESET};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_INSERT:  cost_q.insert  <= cfg_wdata_i;
        REG_REMOVE:  cost_q.remove  <= cfg_wdata_i;
        REG_REPLACE: cost_q.replace <= cfg_wdata_i;
        REG_SWAP:    cost_q.swap    <= cfg_wdata_i;
        default:     cost_q         <= cost_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      left_seen_q <= 1'b0;
      prev_left_q <= '0;
      overflow_q  <= 1'b0;
      cur0_q      <= '0;
      old0_q      <= '0;
      last_q      <= '0;
      cur_sel_q   <= 2'd0;
      old_sel_q   <= 2'd1;
      nxt_sel_q   <= 2'd2;
      issue_q     <= 1'b0;
      k_q         <= '0;
      cmp_valid_q <= 1'b0;
      cmp_first_q <= 1'b0;
      cmp_last_q  <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      // A report loads the result register; otherwise a taken result empties it.
      if (s_fire && (cmd == CMD_REPORT)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            unique case (cmd)
              CMD_CLEAR: begin
                len_q       <= '0;
                left_seen_q <= 1'b0;
                prev_left_q <= '0;
                overflow_q  <= 1'b0;
                cur0_q      <= '0;
                old0_q      <= '0;
                last_q      <= '0;
              end
              CMD_PUSH_RIGHT: begin
                if (!left_seen_q) begin
                  if (len_q == LenMax) begin
                    overflow_q <= 1'b1;
                  end else begin
                    len_q  <= len_q + LW'(1);
                    last_q <= right_val;
                  end
                end
              end
              CMD_PUSH_LEFT: begin
                if (len_q == '0) begin
                  // Only column zero exists: the row finishes at once.
                  cur0_q      <= col0_next;
                  old0_q      <= cur0_q;
                  last_q      <= col0_next;
                  prev_left_q <= s_axis_tdata;
                  left_seen_q <= 1'b1;
                end else begin
                  state_q <= ST_SWEEP;
                  issue_q <= 1'b1;
                  k_q     <= '0;
                end
              end
              CMD_REPORT: begin
                // The result register is loaded above.
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWEEP: begin
          cmp_valid_q <= issue_q;
          if (issue_q) begin
            cmp_first_q <= (k_q == '0);
            cmp_last_q  <= (LW'(k_q) + LW'(1) == len_q);
            if (LW'(k_q) + LW'(1) == len_q) begin
              issue_q <= 1'b0;
            end else begin
              k_q <= k_q + AW'(1);
            end
          end
          if (cmp_valid_q && cmp_last_q) begin
            // Row done: current becomes older, the new row becomes current.
            // The issue stage is already empty, so the compute stage drains too.
            state_q     <= ST_IDLE;
            old_sel_q   <= cur_sel_q;
            cur_sel_q   <= nxt_sel_q;
            nxt_sel_q   <= old_sel_q;
            cur0_q      <= next0_q;
            old0_q      <= cur0_q;
            last_q      <= cell_v;
            prev_left_q <= left_char_q;
            left_seen_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the sweep and the result; no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_fire && (cmd == CMD_PUSH_LEFT)) begin
      left_char_q <= s_axis_tdata;
      next0_q     <= col0_next;
      nxt_prev_q  <= col0_next;
      cur_hold_q  <= cur0_q;
    end else if (cmp_valid_q) begin
      nxt_prev_q <= cell_v;
      cur_hold_q <= cur_rd;
      rs_prev_q  <= rs_rd;
      old_hold_q <= cmp_first_q ? old0_q : old_rd;
    end
    if (state_q == ST_SWEEP && issue_q) begin
      cmp_addr_q <= k_q;
    end
    if (s_fire && (cmd == CMD_REPORT)) begin
      dist_q <= last_ext[15:0];
      ovf_q  <= overflow_q;
    end
  end

  assign last_ext = {16'b0, last_q};

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = dist_q;
  assign m_axis_tuser[0] = ovf_q;

  // The input side is closed for the whole row sweep.
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !s_axis_tready)
    else $error("input accepted during a row sweep");

  // The right length never passes the store depth.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("right length beyond store depth");

  // The three row banks always hold distinct roles.
  a_bank_roles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_sel_q != old_sel_q) && (cur_sel_q != nxt_sel_q) && (old_sel_q != nxt_sel_q))
    else $error("row bank roles collide");

  // A report beat yields a result on the next cycle.
  a_report_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (cmd == CMD_REPORT)) |=> m_axis_tvalid)
    else $error("report produced no result");

endmodule

`default_nettype wire
